// File: rtl/tsc_pkg.sv
package tsc_pkg;

	localparam int MAX_ORDER_DEF   = 4;
	localparam int STORE_DEPTH_DEF = 4096;
	localparam int MAX_DIM_DEF     = 16;

	// element counts and strides of a four-mode tensor with modes of up to 16
	localparam int CW = 17;

	localparam logic [1:0] ACT_LOAD_A  = 2'd0;
	localparam logic [1:0] ACT_LOAD_B  = 2'd1;
	localparam logic [1:0] ACT_COMPUTE = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_SHAPE = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam logic [2:0] REG_ORDER_A = 3'd0;
	localparam logic [2:0] REG_ORDER_B = 3'd1;
	localparam logic [2:0] REG_MODE_A  = 3'd2;
	localparam logic [2:0] REG_MODE_B  = 3'd3;
	localparam logic [2:0] REG_DIMS_A  = 3'd4;
	localparam logic [2:0] REG_DIMS_B  = 3'd5;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD,
		S_SHAPE,
		S_CHECK,
		S_POS,
		S_DIV,
		S_ACC,
		S_RANGE,
		S_MAC,
		S_DRAIN,
		S_RESP
	} state_t;

	typedef struct packed {
		logic       capture;
		logic       load;
		logic       shape_step;
		logic       walk_init;
		logic       div_init;
		logic       div_step;
		logic       acc_digit;
		logic       mac_init;
		logic       mac_issue;
		logic       set_shape_err;
		logic       set_range_err;
		logic       emit;
		logic [2:0] sel;
	} cmd_t;

	typedef struct packed {
		logic       shape_err;
		logic       kept;
		logic       tmp_zero;
		logic       pipe_busy;
		logic [4:0] len;
	} stat_t;

	function automatic logic [4:0] dim_size(input logic [15:0] dims, input logic [1:0] i);
		return {1'b0, dims[{i, 2'b00} +: 4]} + 5'd1;
	endfunction

endpackage

// File: rtl/tsc_ctrl.sv
module tsc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        action,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  tsc_pkg::stat_t    st,
	output tsc_pkg::cmd_t     cmd
);

	tsc_pkg::state_t state_q, state_d;
	logic [2:0] cnt_q;
	logic [1:0] chunk_q;
	logic [4:0] k_q;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tsc_pkg::S_IDLE: begin
				if (in_valid) begin
					case (action) inside
						tsc_pkg::ACT_LOAD_A, tsc_pkg::ACT_LOAD_B: state_d = tsc_pkg::S_LOAD;
						tsc_pkg::ACT_COMPUTE: state_d = tsc_pkg::S_SHAPE;
						default: state_d = tsc_pkg::S_RESP;
					endcase
				end
			end
			tsc_pkg::S_LOAD:  state_d = tsc_pkg::S_RESP;
			tsc_pkg::S_SHAPE: if (cnt_q[1:0] == 2'd3) state_d = tsc_pkg::S_CHECK;
			tsc_pkg::S_CHECK: state_d = st.shape_err ? tsc_pkg::S_RESP : tsc_pkg::S_POS;
			tsc_pkg::S_POS: begin
				if (st.kept) state_d = tsc_pkg::S_DIV;
				else if (cnt_q == 3'd7) state_d = tsc_pkg::S_RANGE;
			end
			tsc_pkg::S_DIV:   if (chunk_q == 2'd2) state_d = tsc_pkg::S_ACC;
			tsc_pkg::S_ACC:   state_d = (cnt_q == 3'd7) ? tsc_pkg::S_RANGE : tsc_pkg::S_POS;
			tsc_pkg::S_RANGE: state_d = st.tmp_zero ? tsc_pkg::S_MAC : tsc_pkg::S_RESP;
			tsc_pkg::S_MAC:   if (k_q == st.len - 5'd1) state_d = tsc_pkg::S_DRAIN;
			tsc_pkg::S_DRAIN: if (!st.pipe_busy) state_d = tsc_pkg::S_RESP;
			tsc_pkg::S_RESP:  if (out_free) state_d = tsc_pkg::S_IDLE;
			default:          state_d = tsc_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.sel = cnt_q;
		in_ready = 1'b0;
		unique case (state_q)
			tsc_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.capture = in_valid;
			end
			tsc_pkg::S_LOAD:  cmd.load = 1'b1;
			tsc_pkg::S_SHAPE: cmd.shape_step = 1'b1;
			tsc_pkg::S_CHECK: begin
				cmd.set_shape_err = st.shape_err;
				cmd.walk_init = !st.shape_err;
			end
			tsc_pkg::S_POS:   cmd.div_init = st.kept;
			tsc_pkg::S_DIV:   cmd.div_step = 1'b1;
			tsc_pkg::S_ACC:   cmd.acc_digit = 1'b1;
			tsc_pkg::S_RANGE: begin
				cmd.mac_init = st.tmp_zero;
				cmd.set_range_err = !st.tmp_zero;
			end
			tsc_pkg::S_MAC:   cmd.mac_issue = 1'b1;
			tsc_pkg::S_DRAIN: ;
			tsc_pkg::S_RESP:  cmd.emit = out_free;
			default:          ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tsc_pkg::S_IDLE;
			cnt_q       <= '0;
			chunk_q     <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				tsc_pkg::S_IDLE:  cnt_q <= '0;
				tsc_pkg::S_SHAPE: cnt_q <= cnt_q + 3'd1;
				tsc_pkg::S_CHECK: cnt_q <= '0;
				tsc_pkg::S_POS: begin
					if (st.kept) chunk_q <= '0;
					else if (cnt_q != 3'd7) cnt_q <= cnt_q + 3'd1;
				end
				tsc_pkg::S_DIV:   chunk_q <= chunk_q + 2'd1;
				tsc_pkg::S_ACC:   cnt_q <= cnt_q + 3'd1;
				tsc_pkg::S_RANGE: k_q <= '0;
				tsc_pkg::S_MAC:   k_q <= k_q + 5'd1;
				default: ;
			endcase
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

// File: rtl/tsc_dp.sv
module tsc_dp #(
	parameter int MAX_ORDER   = tsc_pkg::MAX_ORDER_DEF,
	parameter int STORE_DEPTH = tsc_pkg::STORE_DEPTH_DEF,
	parameter int MAX_DIM     = tsc_pkg::MAX_DIM_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic [1:0]          action,
	input  logic [23:0]         index,
	input  logic signed [31:0]  value,
	input  tsc_pkg::cmd_t       cmd,
	output tsc_pkg::stat_t      st,
	output logic [1:0]          status,
	output logic signed [63:0]  result
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int CW = tsc_pkg::CW;

	logic [2:0]  order_a_q, order_b_q, mode_a_q, mode_b_q;
	logic [15:0] dims_a_q, dims_b_q;

	logic [1:0]         act_q;
	logic [23:0]        idx_q;
	logic signed [31:0] val_q;
	logic [1:0]         res_status_q;
	logic signed [63:0] acc_q;

	logic [CW-1:0] stride_a_q [4];
	logic [CW-1:0] stride_b_q [4];
	logic [CW-1:0] count_a_q, count_b_q;
	logic          dim_err_a_q, dim_err_b_q;

	logic [23:0]   div_sh_q;
	logic [4:0]    rem_q;
	logic [4:0]    divisor_q;
	logic [CW-1:0] off_a_q, off_b_q;
	logic [CW-1:0] addr_a_q, addr_b_q;

	logic [31:0] mem_a [STORE_DEPTH];
	logic [31:0] mem_b [STORE_DEPTH];
	logic signed [31:0] rd_a_s1, rd_b_s1;
	logic               v_s1, v_s2;
	logic signed [63:0] prod_s2;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_a_q <= 3'd1;
			order_b_q <= 3'd1;
			mode_a_q  <= 3'd1;
			mode_b_q  <= 3'd1;
			dims_a_q  <= '0;
			dims_b_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tsc_pkg::REG_ORDER_A: order_a_q <= cfg_data[2:0];
				tsc_pkg::REG_ORDER_B: order_b_q <= cfg_data[2:0];
				tsc_pkg::REG_MODE_A:  mode_a_q  <= cfg_data[2:0];
				tsc_pkg::REG_MODE_B:  mode_b_q  <= cfg_data[2:0];
				tsc_pkg::REG_DIMS_A:  dims_a_q  <= cfg_data;
				tsc_pkg::REG_DIMS_B:  dims_b_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// shape walk
	logic [1:0] si;
	logic [4:0] sd_a, sd_b;
	logic       sin_a, sin_b;
	assign si    = cmd.sel[1:0];
	assign sd_a  = tsc_pkg::dim_size(dims_a_q, si);
	assign sd_b  = tsc_pkg::dim_size(dims_b_q, si);
	assign sin_a = {1'b0, si} < order_a_q;
	assign sin_b = {1'b0, si} < order_b_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			count_a_q   <= CW'(1);
			count_b_q   <= CW'(1);
			dim_err_a_q <= 1'b0;
			dim_err_b_q <= 1'b0;
		end else if (cmd.shape_step) begin
			stride_a_q[si] <= count_a_q;
			stride_b_q[si] <= count_b_q;
			if (sin_a) begin
				count_a_q <= CW'(count_a_q * sd_a);
				if (int'(sd_a) > MAX_DIM) dim_err_a_q <= 1'b1;
			end
			if (sin_b) begin
				count_b_q <= CW'(count_b_q * sd_b);
				if (int'(sd_b) > MAX_DIM) dim_err_b_q <= 1'b1;
			end
		end
	end

	logic [1:0] cm_a, cm_b;
	logic [4:0] len_a, len_b;
	logic       bad_a, bad_b;
	assign cm_a  = mode_a_q[1:0] - 2'd1;
	assign cm_b  = mode_b_q[1:0] - 2'd1;
	assign len_a = tsc_pkg::dim_size(dims_a_q, cm_a);
	assign len_b = tsc_pkg::dim_size(dims_b_q, cm_b);
	assign bad_a = order_a_q == 3'd0 || int'(order_a_q) > MAX_ORDER || mode_a_q == 3'd0
		|| mode_a_q > order_a_q || dim_err_a_q || count_a_q > CW'(STORE_DEPTH);
	assign bad_b = order_b_q == 3'd0 || int'(order_b_q) > MAX_ORDER || mode_b_q == 3'd0
		|| mode_b_q > order_b_q || dim_err_b_q || count_b_q > CW'(STORE_DEPTH);

	// result index decode, one kept mode at a time
	logic [1:0]    pi;
	logic          p_b;
	logic [4:0]    p_size;
	logic [CW-1:0] p_stride;
	assign pi       = cmd.sel[1:0];
	assign p_b      = cmd.sel[2];
	assign p_size   = p_b ? tsc_pkg::dim_size(dims_b_q, pi) : tsc_pkg::dim_size(dims_a_q, pi);
	assign p_stride = p_b ? stride_b_q[pi] : stride_a_q[pi];

	logic [4:0] dr;
	logic [7:0] qb;
	always_comb begin
		dr = rem_q;
		qb = '0;
		for (int j = 7; j >= 0; j--) begin
			dr = {dr[3:0], div_sh_q[16 + j]};
			if (dr >= divisor_q) begin
				dr = dr - divisor_q;
				qb[j] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_init) begin
			div_sh_q <= idx_q;
			off_a_q  <= '0;
			off_b_q  <= '0;
		end else if (cmd.div_init) begin
			rem_q     <= '0;
			divisor_q <= p_size;
		end else if (cmd.div_step) begin
			div_sh_q <= {div_sh_q[15:0], qb};
			rem_q    <= dr;
		end else if (cmd.acc_digit) begin
			if (p_b) off_b_q <= off_b_q + CW'(rem_q[3:0] * p_stride);
			else     off_a_q <= off_a_q + CW'(rem_q[3:0] * p_stride);
		end
	end

	// contraction walk
	always_ff @(posedge clk) begin
		if (cmd.mac_init) begin
			addr_a_q <= off_a_q;
			addr_b_q <= off_b_q;
		end else if (cmd.mac_issue) begin
			addr_a_q <= addr_a_q + stride_a_q[cm_a];
			addr_b_q <= addr_b_q + stride_b_q[cm_b];
		end
	end

	logic we_a, we_b, ld_ok;
	assign ld_ok = idx_q < 24'(STORE_DEPTH);
	assign we_a  = cmd.load && ld_ok && act_q == tsc_pkg::ACT_LOAD_A;
	assign we_b  = cmd.load && ld_ok && act_q == tsc_pkg::ACT_LOAD_B;

	always_ff @(posedge clk) begin
		if (we_a) mem_a[idx_q[AW-1:0]] <= val_q;
		rd_a_s1 <= mem_a[addr_a_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (we_b) mem_b[idx_q[AW-1:0]] <= val_q;
		rd_b_s1 <= mem_b[addr_b_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.mac_issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= rd_a_s1 * rd_b_s1;
	end

	logic signed [64:0] sum;
	logic signed [63:0] sum_sat;
	assign sum = {acc_q[63], acc_q} + {prod_s2[63], prod_s2};
	always_comb begin
		sum_sat = sum[63:0];
		if (sum[64] != sum[63]) sum_sat = sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
	end

	// request capture and response
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q        <= action;
			idx_q        <= index;
			val_q        <= value;
			res_status_q <= tsc_pkg::ST_OK;
			acc_q        <= '0;
		end else begin
			if (cmd.load && !ld_ok) res_status_q <= tsc_pkg::ST_RANGE;
			if (cmd.set_shape_err)  res_status_q <= tsc_pkg::ST_SHAPE;
			if (cmd.set_range_err)  res_status_q <= tsc_pkg::ST_RANGE;
			if (v_s2) acc_q <= sum_sat;
		end
		if (cmd.emit) begin
			status <= res_status_q;
			result <= acc_q;
		end
	end

	assign st.shape_err = bad_a || bad_b || len_a != len_b;
	assign st.kept      = p_b ? ({1'b0, pi} < order_b_q && pi != cm_b)
	                          : ({1'b0, pi} < order_a_q && pi != cm_a);
	assign st.tmp_zero  = div_sh_q == '0;
	assign st.pipe_busy = v_s1 || v_s2;
	assign st.len       = len_a;

endmodule

// File: rtl/tensor_single_mode_contraction_top.sv
// channel   signals                               accepted when
// in        in_valid/in_ready action index value  in_valid && in_ready
// out       out_valid/out_ready status result     out_valid && out_ready
// cfg       cfg_we cfg_index cfg_data             cfg_we
//
// One request at a time. A load goes through idle, write and response, an
// unused action through idle and response. A compute walks the shape, checks
// it, decodes the result index one kept mode at a time, checks the range and
// runs the multiply-accumulate; an error ends it. The divider retires 8 index
// bits a cycle and the multiply-accumulate reads one element pair per cycle.
// Reset clears control and config; the element stores are not cleared.
// A response waiting in the output register does not block the next request;
// the response cycle holds while that earlier response is still waiting.
module tensor_single_mode_contraction_top #(
	parameter int MAX_ORDER   = tsc_pkg::MAX_ORDER_DEF,
	parameter int STORE_DEPTH = tsc_pkg::STORE_DEPTH_DEF,
	parameter int MAX_DIM     = tsc_pkg::MAX_DIM_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         action,
	input  logic [23:0]        index,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic signed [63:0] result
);

	tsc_pkg::cmd_t  cmd;
	tsc_pkg::stat_t st;

	tsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.action    (action),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	tsc_dp #(
		.MAX_ORDER   (MAX_ORDER),
		.STORE_DEPTH (STORE_DEPTH),
		.MAX_DIM     (MAX_DIM)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.action    (action),
		.index     (index),
		.value     (value),
		.cmd       (cmd),
		.st        (st),
		.status    (status),
		.result    (result)
	);

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while busy");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != tsc_pkg::ST_OK |-> result == 64'd0)
		else $error("nonzero result with error status");

	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.mac_issue, cmd.emit, cmd.capture}))
		else $error("conflicting datapath commands");

	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid)
		else $error("response lost");

endmodule

// File: tb/tensor_single_mode_contraction_top_tb.sv
module tensor_single_mode_contraction_top_tb;

	localparam int DEPTH = 4096;
	localparam int ITEM_GOAL = 1800;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int SETTLE = 120;
	localparam logic [1:0] ACT_NONE = 2'd3;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		logic [2:0]         code;
		logic [23:0]        idx;
		logic [31:0]        val;
		bit                 typed;
		logic [1:0]         st;
		logic signed [63:0] res;
	} stim_row_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [15:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         action;
	logic [23:0]        index;
	logic signed [31:0] value;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         status;
	logic signed [63:0] result;

	tensor_single_mode_contraction_top dut (.*);

	// shadow of the configuration and of both element stores
	logic [2:0]  ord_a, ord_b, con_a, con_b;
	logic [15:0] shp_a, shp_b;
	logic [31:0] elem_a [DEPTH];
	logic [31:0] elem_b [DEPTH];
	bit          seen_a [DEPTH];
	bit          seen_b [DEPTH];
	int          read_a [16];
	int          read_b [16];
	int          n_reads;

	logic [1:0]         want_status [$];
	logic signed [63:0] want_result [$];

	stim_row_t stim_rows [$];
	int        fails = 0;
	int        cycle = 0;
	int        item_count = 0;
	bit        calm;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > CYCLE_LIMIT) begin
			$display("tensor_single_mode_contraction_top test failed");
			$finish;
		end
	end

	assign calm = cycle >= 2500 && cycle < 5500;

	always @(posedge clk) begin
		out_ready <= calm || $urandom_range(99) >= 30;
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (want_status.size() == 0) begin
				$error("response with nothing pending: status %0d result %0d", status, result);
				fails++;
			end else begin
				if (status !== want_status[0]) begin
					$error("status expected %0d got %0d", want_status[0], status);
					fails++;
				end
				if (result !== want_result[0]) begin
					$error("result expected %0d got %0d", want_result[0], result);
					fails++;
				end
				void'(want_status.pop_front());
				void'(want_result.pop_front());
			end
		end
	end

	function automatic int msize(logic [15:0] dims, int i);
		return int'(dims[4 * (i & 3) +: 4]) + 1;
	endfunction

	// product of the first n mode sizes; also the column-major stride of mode n
	function automatic int elem_count(int n, logic [15:0] dims);
		int c = 1;
		for (int i = 0; i < n; i++)
			c *= msize(dims, i);
		return c;
	endfunction

	function automatic bit shape_ok(logic [2:0] ord, logic [2:0] md, logic [15:0] dims);
		if (ord < 1 || ord > 4)
			return 0;
		if (md < 1 || md > ord)
			return 0;
		return elem_count(ord, dims) <= DEPTH;
	endfunction

	// one result element; records the store offsets it reads
	function automatic void contract(input logic [23:0] idx, output logic [1:0] st,
			output logic signed [63:0] res, output longint tot);
		int     rd [8];
		int     ia [4];
		int     ib [4];
		int     n, len, oa, ob;
		longint rest;
		logic signed [63:0] pa, pb, prod;
		logic signed [64:0] sum;
		st = tsc_pkg::ST_OK;
		res = '0;
		tot = 0;
		n_reads = 0;
		if (!shape_ok(ord_a, con_a, shp_a) || !shape_ok(ord_b, con_b, shp_b)) begin
			st = tsc_pkg::ST_SHAPE;
			return;
		end
		len = msize(shp_a, con_a - 1);
		if (len != msize(shp_b, con_b - 1)) begin
			st = tsc_pkg::ST_SHAPE;
			return;
		end
		n = 0;
		tot = 1;
		for (int i = 0; i < ord_a; i++)
			if (i != con_a - 1) begin
				rd[n] = msize(shp_a, i);
				tot *= rd[n];
				n++;
			end
		for (int i = 0; i < ord_b; i++)
			if (i != con_b - 1) begin
				rd[n] = msize(shp_b, i);
				tot *= rd[n];
				n++;
			end
		if (longint'(idx) >= tot) begin
			st = tsc_pkg::ST_RANGE;
			return;
		end
		rest = idx;
		n = 0;
		for (int i = 0; i < ord_a; i++) begin
			ia[i] = 0;
			if (i != con_a - 1) begin
				ia[i] = int'(rest % rd[n]);
				rest /= rd[n];
				n++;
			end
		end
		for (int i = 0; i < ord_b; i++) begin
			ib[i] = 0;
			if (i != con_b - 1) begin
				ib[i] = int'(rest % rd[n]);
				rest /= rd[n];
				n++;
			end
		end
		for (int k = 0; k < len; k++) begin
			ia[con_a - 1] = k;
			ib[con_b - 1] = k;
			oa = 0;
			ob = 0;
			for (int i = 0; i < ord_a; i++)
				oa += ia[i] * elem_count(i, shp_a);
			for (int i = 0; i < ord_b; i++)
				ob += ib[i] * elem_count(i, shp_b);
			read_a[k] = oa;
			read_b[k] = ob;
			pa = $signed(elem_a[oa]);
			pb = $signed(elem_b[ob]);
			prod = pa * pb;
			sum = {res[63], res} + {prod[63], prod};
			if (sum > 65'sh0_7FFF_FFFF_FFFF_FFFF)
				res = 64'sh7FFF_FFFF_FFFF_FFFF;
			else if (sum < -65'sh0_8000_0000_0000_0000)
				res = 64'sh8000_0000_0000_0000;
			else
				res = sum[63:0];
		end
		n_reads = len;
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(19))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// call at a rising edge; returns at the edge where the request was taken
	task automatic send(logic [1:0] act, logic [23:0] idx, logic [31:0] val,
			bit typed = 0, logic [1:0] st_t = tsc_pkg::ST_OK,
			logic signed [63:0] res_t = '0);
		logic [1:0]         st;
		logic signed [63:0] res;
		longint             tot;
		while (!calm && $urandom_range(99) < 30) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		index <= idx;
		value <= val;
		do
			@(posedge clk);
		while (!in_ready);
		st = tsc_pkg::ST_OK;
		res = '0;
		case (act) inside
			tsc_pkg::ACT_LOAD_A, tsc_pkg::ACT_LOAD_B: begin
				if (idx >= DEPTH) begin
					st = tsc_pkg::ST_RANGE;
				end else if (act == tsc_pkg::ACT_LOAD_A) begin
					elem_a[idx] = val;
					seen_a[idx] = 1;
				end else begin
					elem_b[idx] = val;
					seen_b[idx] = 1;
				end
			end
			tsc_pkg::ACT_COMPUTE: contract(idx, st, res, tot);
			default: ;
		endcase
		if (typed) begin
			if (st !== st_t || res !== res_t) begin
				$error("table row: status expected %0d got %0d, result expected %0d got %0d",
					st_t, st, res_t, res);
				fails++;
			end
		end
		want_status = {want_status, st};
		want_result = {want_result, res};
		if (act != ACT_NONE)
			item_count++;
	endtask

	// hold off until every response is back and the block has gone quiet
	task automatic drain();
		in_valid <= 1'b0;
		while (want_status.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// one write, then cfg_we held low before returning so back-to-back writes never clash
	task automatic cfg_write(logic [2:0] reg_idx, logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_index <= reg_idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (reg_idx)
			tsc_pkg::REG_ORDER_A: ord_a = data[2:0];
			tsc_pkg::REG_ORDER_B: ord_b = data[2:0];
			tsc_pkg::REG_MODE_A:  con_a = data[2:0];
			tsc_pkg::REG_MODE_B:  con_b = data[2:0];
			tsc_pkg::REG_DIMS_A:  shp_a = data;
			tsc_pkg::REG_DIMS_B:  shp_b = data;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// load whatever a compute at idx would read that is still unwritten, then run it
	task automatic compute_at(logic [23:0] idx);
		logic [1:0]         st;
		logic signed [63:0] res;
		longint             tot;
		contract(idx, st, res, tot);
		if (st == tsc_pkg::ST_OK)
			for (int k = 0; k < n_reads; k++) begin
				if (!seen_a[read_a[k]])
					send(tsc_pkg::ACT_LOAD_A, 24'(read_a[k]), pick_value());
				if (!seen_b[read_b[k]])
					send(tsc_pkg::ACT_LOAD_B, 24'(read_b[k]), pick_value());
			end
		send(tsc_pkg::ACT_COMPUTE, idx, '0);
	endtask

	function automatic stim_row_t mk(row_kind_t kind, logic [2:0] code, logic [23:0] idx,
			logic [31:0] val, bit typed = 0, logic [1:0] st = tsc_pkg::ST_OK,
			logic signed [63:0] res = '0);
		stim_row_t r;
		r = '{kind, code, idx, val, typed, st, res};
		return r;
	endfunction

	task automatic random_config();
		logic [2:0]  oa, ob, ma, mb;
		logic [15:0] da, db;
		int          f;
		do begin
			oa = 3'($urandom_range(1, 4));
			ob = 3'($urandom_range(1, 4));
			ma = 3'($urandom_range(1, oa));
			mb = 3'($urandom_range(1, ob));
			da = 16'($urandom);
			db = 16'($urandom);
			for (int j = 0; j < 4; j++) begin
				da[4 * j +: 4] = $urandom_range(9) == 0 ? 4'hF : 4'($urandom_range(3));
				db[4 * j +: 4] = $urandom_range(9) == 0 ? 4'hF : 4'($urandom_range(3));
			end
			if ($urandom_range(3) == 0)
				da[4 * (ma - 1) +: 4] = 4'hF;
			db[4 * (mb - 1) +: 4] = da[4 * (ma - 1) +: 4];
		end while (elem_count(oa, da) > DEPTH || elem_count(ob, db) > DEPTH);
		if ($urandom_range(99) < 15) begin
			f = $urandom_range(4);
			case (f)
				0: oa = 3'($urandom_range(2)) == 0 ? 3'd0 : 3'($urandom_range(5, 7));
				1: mb = $urandom_range(1) ? 3'd0 : 3'($urandom_range(ob + 1, 7));
				2: db[4 * (mb - 1) +: 4] = da[4 * (ma - 1) +: 4] + 4'($urandom_range(1, 15));
				3: begin
					oa = 3'd4;
					da = 16'hFFFF;
				end
				default: ma = 3'd0;
			endcase
		end
		cfg_write(tsc_pkg::REG_ORDER_A, {13'd0, oa});
		cfg_write(tsc_pkg::REG_ORDER_B, {13'd0, ob});
		cfg_write(tsc_pkg::REG_MODE_A, {13'd0, ma});
		cfg_write(tsc_pkg::REG_MODE_B, {13'd0, mb});
		cfg_write(tsc_pkg::REG_DIMS_A, da);
		cfg_write(tsc_pkg::REG_DIMS_B, db);
	endtask

	initial begin
		logic [1:0]         st;
		logic signed [63:0] res;
		longint             tot;
		int                 size_a, size_b, pick;

		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		action = tsc_pkg::ACT_LOAD_A;
		index = '0;
		value = '0;
		out_ready = 1'b0;
		ord_a = 3'd1;
		ord_b = 3'd1;
		con_a = 3'd1;
		con_b = 3'd1;
		shp_a = '0;
		shp_b = '0;
		for (int i = 0; i < DEPTH; i++) begin
			elem_a[i] = '0;
			elem_b[i] = '0;
			seen_a[i] = 0;
			seen_b[i] = 0;
		end

		// reset shape is a scalar times a scalar
		stim_rows = {stim_rows, mk(ROW_ITEM, tsc_pkg::ACT_LOAD_A, 24'd0, 32'h7FFF_FFFF, 1)};
		stim_rows = {stim_rows, mk(ROW_ITEM, tsc_pkg::ACT_LOAD_B, 24'd0, 32'h7FFF_FFFF, 1)};
		stim_rows = {stim_rows, mk(ROW_ITEM, tsc_pkg::ACT_COMPUTE, 24'd0, 32'h0)};
		stim_rows = {stim_rows, mk(ROW_ITEM, tsc_pkg::ACT_COMPUTE, 24'd1, 32'h0, 1,
			tsc_pkg::ST_RANGE)};
		stim_rows = {stim_rows, mk(ROW_ITEM, tsc_pkg::ACT_COMPUTE, 24'hFF_FFFF, 32'hFFFF_FFFF, 1,
			tsc_pkg::ST_RANGE)};
		stim_rows = {stim_rows, mk(ROW_ITEM, tsc_pkg::ACT_LOAD_A, 24'd4096, 32'h1234_5678, 1,
			tsc_pkg::ST_RANGE)};
		stim_rows = {stim_rows, mk(ROW_ITEM, tsc_pkg::ACT_LOAD_B, 24'hFF_FFFF, 32'h8000_0000, 1,
			tsc_pkg::ST_RANGE)};
		stim_rows = {stim_rows, mk(ROW_ITEM, ACT_NONE, 24'hFF_FFFF, 32'hFFFF_FFFF, 1)};
		stim_rows = {stim_rows, mk(ROW_ITEM, tsc_pkg::ACT_LOAD_A, 24'd0, 32'h8000_0000, 1)};
		stim_rows = {stim_rows, mk(ROW_ITEM, tsc_pkg::ACT_LOAD_B, 24'd0, 32'h8000_0000, 1)};
		stim_rows = {stim_rows, mk(ROW_ITEM, tsc_pkg::ACT_COMPUTE, 24'd0, 32'h0, 1,
			tsc_pkg::ST_OK, 64'sh4000_0000_0000_0000)};
		stim_rows = {stim_rows, mk(ROW_CFG, tsc_pkg::REG_ORDER_A, 24'd0, 32'd5)};
		stim_rows = {stim_rows, mk(ROW_ITEM, tsc_pkg::ACT_COMPUTE, 24'd0, 32'h0, 1,
			tsc_pkg::ST_SHAPE)};
		stim_rows = {stim_rows, mk(ROW_CFG, tsc_pkg::REG_ORDER_A, 24'd0, 32'd1)};
		stim_rows = {stim_rows, mk(ROW_CFG, tsc_pkg::REG_MODE_B, 24'd0, 32'd2)};
		stim_rows = {stim_rows, mk(ROW_ITEM, tsc_pkg::ACT_COMPUTE, 24'd0, 32'h0, 1,
			tsc_pkg::ST_SHAPE)};
		stim_rows = {stim_rows, mk(ROW_CFG, tsc_pkg::REG_MODE_B, 24'd0, 32'd1)};
		stim_rows = {stim_rows, mk(ROW_CFG, tsc_pkg::REG_DIMS_A, 24'd0, 32'h1)};
		stim_rows = {stim_rows, mk(ROW_ITEM, tsc_pkg::ACT_COMPUTE, 24'd0, 32'h0, 1,
			tsc_pkg::ST_SHAPE)};
		stim_rows = {stim_rows, mk(ROW_CFG, tsc_pkg::REG_DIMS_B, 24'd0, 32'h1)};
		stim_rows = {stim_rows, mk(ROW_ITEM, tsc_pkg::ACT_LOAD_A, 24'd1, 32'hFFFF_FFFF, 1)};
		stim_rows = {stim_rows, mk(ROW_ITEM, tsc_pkg::ACT_LOAD_B, 24'd1, 32'h0000_0001, 1)};
		stim_rows = {stim_rows, mk(ROW_ITEM, tsc_pkg::ACT_COMPUTE, 24'd0, 32'h0)};
		stim_rows = {stim_rows, mk(ROW_CFG, tsc_pkg::REG_ORDER_A, 24'd0, 32'd4)};
		stim_rows = {stim_rows, mk(ROW_CFG, tsc_pkg::REG_DIMS_A, 24'd0, 32'hFFFF)};
		stim_rows = {stim_rows, mk(ROW_ITEM, tsc_pkg::ACT_COMPUTE, 24'd0, 32'h0, 1,
			tsc_pkg::ST_SHAPE)};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i]) begin
			if (stim_rows[i].kind == ROW_CFG) begin
				drain();
				cfg_write(stim_rows[i].code, stim_rows[i].val[15:0]);
			end else begin
				send(stim_rows[i].code[1:0], stim_rows[i].idx, stim_rows[i].val,
					stim_rows[i].typed, stim_rows[i].st, stim_rows[i].res);
			end
		end

		// sixteen extreme products: saturate high, then low
		drain();
		cfg_write(tsc_pkg::REG_ORDER_A, 16'd1);
		cfg_write(tsc_pkg::REG_MODE_A, 16'd1);
		cfg_write(tsc_pkg::REG_DIMS_A, 16'h000F);
		cfg_write(tsc_pkg::REG_DIMS_B, 16'hFFFF);
		for (int k = 0; k < 16; k++) begin
			send(tsc_pkg::ACT_LOAD_A, 24'(k), 32'h8000_0000);
			send(tsc_pkg::ACT_LOAD_B, 24'(k), 32'h8000_0000);
		end
		send(tsc_pkg::ACT_COMPUTE, 24'd0, '0, 1, tsc_pkg::ST_OK, 64'sh7FFF_FFFF_FFFF_FFFF);
		for (int k = 0; k < 16; k++)
			send(tsc_pkg::ACT_LOAD_B, 24'(k), 32'h7FFF_FFFF);
		send(tsc_pkg::ACT_COMPUTE, 24'd0, '0, 1, tsc_pkg::ST_OK, 64'sh8000_0000_0000_0000);

		while (item_count < ITEM_GOAL) begin
			drain();
			random_config();
			contract(24'd0, st, res, tot);
			size_a = shape_ok(ord_a, con_a, shp_a) ? elem_count(ord_a, shp_a) : DEPTH;
			size_b = shape_ok(ord_b, con_b, shp_b) ? elem_count(ord_b, shp_b) : DEPTH;
			repeat ($urandom_range(30, 80)) begin
				pick = $urandom_range(99);
				if (pick < 55) begin
					if (st == tsc_pkg::ST_OK && tot > 0 && $urandom_range(9) != 0)
						compute_at(24'($urandom_range(0, int'(tot) - 1)));
					else if (st == tsc_pkg::ST_OK && $urandom_range(1))
						compute_at(24'(tot));
					else
						compute_at(24'($urandom_range(0, 24'hFF_FFFF)));
				end else if (pick < 85) begin
					if ($urandom_range(1))
						send(tsc_pkg::ACT_LOAD_A, 24'($urandom_range(0, size_a - 1)),
							pick_value());
					else
						send(tsc_pkg::ACT_LOAD_B, 24'($urandom_range(0, size_b - 1)),
							pick_value());
				end else if (pick < 95) begin
					send($urandom_range(1) ? tsc_pkg::ACT_LOAD_A : tsc_pkg::ACT_LOAD_B,
						24'($urandom_range(DEPTH, 24'hFF_FFFF)), $urandom);
				end else begin
					send(ACT_NONE, 24'($urandom_range(0, 24'hFF_FFFF)), $urandom);
				end
			end
		end

		drain();
		if (fails == 0)
			$display("tensor_single_mode_contraction_top test passed");
		else
			$display("tensor_single_mode_contraction_top test failed");
		$finish;
	end

endmodule
